@@ hdl/enit_pkg.sv @@
// enit_pkg: shared types and constants for the expression node interning table.
// No dependencies.
`default_nettype none
package enit_pkg;
   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BADOP = 2'd2;
   localparam logic [2:0] KIND_CONST = 3'd0;
   localparam logic [2:0] KIND_VAR = 3'd1;
   localparam logic [2:0] KIND_BINARY = 3'd2;
   localparam logic [2:0] KIND_UNARY = 3'd3;
   localparam logic [2:0] KIND_MEMBER = 3'd5;
   localparam logic [2:0] KIND_ARROW = 3'd6;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  op;
      logic        share;
      logic [2:0]  cnt;
      logic [3:0]  nlen;
      logic [3:0][9:0] ids;
      logic [63:0] cbits;
      logic [63:0] name;
   } item_type;

   // 64-bit multiply by the FNV prime: prime = 2^40 + 0x1b3, so shift plus narrow product.
   function automatic logic [63:0] fnv_byte(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x * 64'h1b3);
   endfunction

   function automatic logic dbl_nan(input logic [63:0] b);
      return (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
   endfunction
endpackage
`default_nettype wire

@@ hdl/enit_front.sv @@
// enit_front: input beat capture, field saturation and name masking, two-entry queue.
// Depends on enit_pkg.
`default_nettype none
module enit_front #(
   parameter int MAX_OPERANDS = 4,
   parameter int MAX_NAME_CHARS = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   output logic in_ready,
   input  wire enit_pkg::item_type in_item,
   output logic q_valid,
   input  wire logic q_ready,
   output enit_pkg::item_type q_item
);
   localparam logic [2:0] LIM = 3'((MAX_OPERANDS < 4) ? MAX_OPERANDS : 4);
   localparam logic [3:0] NMAX = 4'(MAX_NAME_CHARS);
   enit_pkg::item_type slot_ff [2];
   logic [1:0] cnt_ff;
   logic       rd_ff, wr_ff;
   enit_pkg::item_type cl;
   logic push, pop;

   always_comb begin
      cl = in_item;
      if (in_item.cnt > LIM) cl.cnt = LIM;
      if (in_item.nlen > NMAX) cl.nlen = NMAX;
      for (int i = 0; i < 8; i++)
         if (4'(i) >= cl.nlen) cl.name[i*8 +: 8] = 8'd0;
   end

   assign in_ready = (cnt_ff != 2'd2);
   assign push = in_valid && in_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_item = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= cl;
      if (reset) begin
         cnt_ff <= 2'd0; rd_ff <= 1'b0; wr_ff <= 1'b0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule
`default_nettype wire

@@ hdl/enit_back.sv @@
// enit_back: sequencer for hashing, bucket scan, node store and result register.
// Depends on enit_pkg.
`default_nettype none
module enit_back #(
   parameter int NODE_CAPACITY = 1024,
   parameter int BUCKET_COUNT = 256,
   parameter int BUCKET_WAYS = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic q_valid,
   output logic q_ready,
   input  wire enit_pkg::item_type q_item,
   output logic o_valid,
   input  wire logic o_ready,
   output logic [9:0] o_node_id,
   output logic o_reused,
   output logic [63:0] o_node_hash,
   output logic [1:0] o_status
);
   localparam int IW = $clog2(NODE_CAPACITY);
   localparam int BW = $clog2(BUCKET_COUNT);
   localparam int WW = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
   localparam int TD = BUCKET_COUNT * BUCKET_WAYS;
   localparam int TW = $clog2(TD);

   localparam logic [3:0] S_IDLE = 4'd0, S_CHK = 4'd1, S_MIX = 4'd2, S_OPRD = 4'd3,
                          S_OPWT = 4'd4, S_STORE = 4'd5, S_BRD = 4'd6, S_BWT = 4'd7,
                          S_NRD = 4'd8, S_NWT = 4'd9, S_CMP = 4'd10, S_OUT = 4'd11,
                          S_CLR = 4'd12;

   logic [18:0] head_mem [NODE_CAPACITY];   // kind, op, nlen, cnt
   logic [39:0] link_mem [NODE_CAPACITY];
   logic [63:0] const_mem [NODE_CAPACITY];
   logic [63:0] name_mem [NODE_CAPACITY];
   logic [63:0] hval_mem [NODE_CAPACITY];
   logic [IW:0] bkt_mem [TD];               // valid bit over node id

   logic [3:0]  state_ff;
   enit_pkg::item_type it_ff;
   logic [IW:0] next_ff;
   logic [63:0] h_ff, val_ff, rdh_ff;
   logic [4:0]  step_ff;      // value index in mix sequence
   logic [2:0]  byte_ff;
   logic [2:0]  opi_ff;
   logic [WW:0] way_ff;
   logic [IW-1:0] me_ff, cand_ff;
   logic [IW:0] bkt_rd_ff;
   logic [TW-1:0] clr_ff;
   logic [18:0] hd_rd_ff; logic [39:0] lk_rd_ff; logic [63:0] cs_rd_ff, nm_rd_ff;
   logic [63:0] hv_rd_ff;
   logic [TW-1:0] baddr;

   assign baddr = TW'({h_ff[BW-1:0], {WW{1'b0}}} >> (WW - ((BUCKET_WAYS > 1) ? WW : 0))) +
                  TW'(way_ff[WW-1:0]);

   // Index into the value sequence: 0 kind,1 op,2 cnt,3.. operands, names, const.
   logic [63:0] cur_val;
   logic [4:0] n_ops_end, n_nm_end, n_all;
   always_comb begin
      n_ops_end = 5'd3 + 5'(it_ff.cnt);
      n_nm_end = n_ops_end + 5'(it_ff.nlen);
      n_all = n_nm_end + 5'(it_ff.kind == enit_pkg::KIND_CONST);
      if (step_ff == 5'd0) cur_val = 64'(it_ff.kind);
      else if (step_ff == 5'd1) cur_val = 64'(it_ff.op);
      else if (step_ff == 5'd2) cur_val = 64'(it_ff.cnt);
      else if (step_ff < n_ops_end) cur_val = rdh_ff;
      else if (step_ff < n_nm_end)
         cur_val = 64'(it_ff.name[(step_ff - n_ops_end) * 8 +: 8]);
      else cur_val = it_ff.cbits;
   end

   logic eq;
   always_comb begin
      eq = (hv_rd_ff == h_ff) && (hd_rd_ff[10:0] == {it_ff.op, it_ff.kind}) &&
           (hd_rd_ff[18:15] == {1'b0, it_ff.cnt});
      for (int i = 0; i < 4; i++)
         if (3'(i) < it_ff.cnt && lk_rd_ff[i*10 +: 10] != it_ff.ids[i]) eq = 1'b0;
      if (it_ff.kind == enit_pkg::KIND_CONST &&
          (enit_pkg::dbl_nan(cs_rd_ff) || enit_pkg::dbl_nan(it_ff.cbits) ||
           !(((cs_rd_ff << 1) == 64'd0 && (it_ff.cbits << 1) == 64'd0) ||
             cs_rd_ff == it_ff.cbits))) eq = 1'b0;
      if ((it_ff.kind == enit_pkg::KIND_VAR || it_ff.kind == enit_pkg::KIND_MEMBER ||
           it_ff.kind == enit_pkg::KIND_ARROW) &&
          (hd_rd_ff[14:11] != it_ff.nlen || nm_rd_ff != it_ff.name)) eq = 1'b0;
   end

   logic [9:0] opid;
   logic bad;
   always_comb begin
      opid = it_ff.ids[opi_ff[1:0]];
      bad = 1'b0;
      for (int i = 0; i < 4; i++)
         if (3'(i) < it_ff.cnt && {1'b0, it_ff.ids[i]} >= 11'(next_ff)) bad = 1'b1;
   end

   assign q_ready = (state_ff == S_IDLE);
   assign o_valid = (state_ff == S_OUT);

   always_ff @(posedge clock) begin
      // registered memory reads
      rdh_ff <= hval_mem[IW'(opid)];
      bkt_rd_ff <= bkt_mem[baddr];
      hv_rd_ff <= hval_mem[cand_ff];
      hd_rd_ff <= head_mem[cand_ff];
      lk_rd_ff <= link_mem[cand_ff];
      cs_rd_ff <= const_mem[cand_ff];
      nm_rd_ff <= name_mem[cand_ff];
      if (reset) begin
         state_ff <= S_CLR; next_ff <= '0; clr_ff <= '0;
      end else begin
         case (state_ff)
            // one bucket entry invalidated per cycle after reset
            S_CLR: begin
               bkt_mem[clr_ff] <= '0;
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == TW'(TD - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (q_valid) begin
               it_ff <= q_item; state_ff <= S_CHK;
            end
            S_CHK: begin
               h_ff <= enit_pkg::FNV_BASIS; step_ff <= 5'd0; byte_ff <= 3'd0;
               opi_ff <= 3'd0; val_ff <= 64'(it_ff.kind);
               me_ff <= next_ff[IW-1:0];
               o_node_id <= 10'd0; o_reused <= 1'b0; o_node_hash <= 64'd0;
               if (next_ff >= (IW+1)'(NODE_CAPACITY)) begin
                  o_status <= enit_pkg::ST_FULL; state_ff <= S_OUT;
               end else if (bad) begin
                  o_status <= enit_pkg::ST_BADOP; state_ff <= S_OUT;
               end else begin
                  o_status <= enit_pkg::ST_OK; state_ff <= S_MIX;
               end
            end
            S_MIX: begin
               h_ff <= enit_pkg::fnv_byte(h_ff, val_ff[byte_ff*8 +: 8]);
               byte_ff <= byte_ff + 3'd1;
               if (byte_ff == 3'd7) begin
                  step_ff <= step_ff + 5'd1;
                  state_ff <= S_OPRD;
               end
            end
            S_OPRD: begin
               // step_ff now names the next value; fetch operand hash if needed
               if (step_ff == n_all) state_ff <= S_STORE;
               else if (step_ff >= 5'd3 && step_ff < n_ops_end) begin
                  state_ff <= S_OPWT;
               end else begin
                  val_ff <= cur_val; state_ff <= S_MIX;
               end
            end
            S_OPWT: begin
               val_ff <= rdh_ff; opi_ff <= opi_ff + 3'd1; state_ff <= S_MIX;
            end
            S_STORE: begin
               hval_mem[me_ff] <= h_ff;
               head_mem[me_ff] <= {1'b0, it_ff.cnt, it_ff.nlen, it_ff.op, it_ff.kind};
               link_mem[me_ff] <= it_ff.ids;
               const_mem[me_ff] <= it_ff.cbits;
               name_mem[me_ff] <= it_ff.name;
               next_ff <= next_ff + 1'b1;
               o_node_id <= 10'(me_ff); o_node_hash <= h_ff;
               way_ff <= '0;
               state_ff <= it_ff.share ? S_BRD : S_OUT;
            end
            // bucket entry is read here, checked in S_BWT
            S_BRD: begin
               if (way_ff == (WW+1)'(BUCKET_WAYS)) state_ff <= S_OUT;
               else state_ff <= S_BWT;
            end
            S_BWT: begin
               if (!bkt_rd_ff[IW]) begin
                  bkt_mem[baddr] <= {1'b1, me_ff}; state_ff <= S_OUT;
               end else begin
                  cand_ff <= bkt_rd_ff[IW-1:0]; state_ff <= S_NRD;
               end
            end
            S_NRD: state_ff <= S_NWT;
            S_NWT: state_ff <= S_CMP;
            S_CMP: if (eq) begin
               o_node_id <= 10'(cand_ff); o_reused <= 1'b1; state_ff <= S_OUT;
            end else begin
               way_ff <= way_ff + 1'b1; state_ff <= S_BRD;
            end
            S_OUT: if (o_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ hdl/expression_node_interning_table.sv @@
// expression_node_interning_table: top level, front queue plus back sequencer.
// Depends on enit_pkg, enit_front, enit_back.
//
//  channel | ports  | beat
//  input   | req_*  | one node description
//  result  | rsp_*  | node id, reuse flag, hash, status
//
// Back end per item: pickup and check, then a byte-serial mix of each value (kind, op,
// count, operand hashes, name chars, const) with a fetch before each operand hash, a store,
// a read and compare per bucket way, a record if a way is free, then the beat.
// Errors go from the check straight to the beat. The byte-serial FNV mix sets the item time.
// Reset zeroes next id and clears all BUCKET_COUNT*BUCKET_WAYS bucket entries.
// A two-entry queue keeps taking beats, until it holds two, while the back end works or stalls.
`default_nettype none
module expression_node_interning_table #(
   parameter int NODE_CAPACITY = 1024,
   parameter int BUCKET_COUNT = 256,
   parameter int BUCKET_WAYS = 4,
   parameter int MAX_OPERANDS = 4,
   parameter int MAX_NAME_CHARS = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [2:0] req_kind_code,
   input  wire logic [7:0] req_op_code,
   input  wire logic req_shareable,
   input  wire logic [2:0] req_operand_count,
   input  wire logic [9:0] req_operand0_id,
   input  wire logic [9:0] req_operand1_id,
   input  wire logic [9:0] req_operand2_id,
   input  wire logic [9:0] req_operand3_id,
   input  wire logic [63:0] req_const_bits,
   input  wire logic [63:0] req_name_chars,
   input  wire logic [3:0] req_name_len,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [9:0] rsp_node_id,
   output logic rsp_reused,
   output logic [63:0] rsp_node_hash,
   output logic [1:0] rsp_status
);
   enit_pkg::item_type in_item, q_item;
   logic q_valid, q_ready;

   always_comb begin
      in_item.kind = req_kind_code;
      in_item.op = req_op_code;
      in_item.share = req_shareable;
      in_item.cnt = req_operand_count;
      in_item.nlen = req_name_len;
      in_item.ids = {req_operand3_id, req_operand2_id, req_operand1_id, req_operand0_id};
      in_item.cbits = req_const_bits;
      in_item.name = req_name_chars;
   end

   enit_front #(.MAX_OPERANDS(MAX_OPERANDS), .MAX_NAME_CHARS(MAX_NAME_CHARS)) u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_ready(req_ready),
      .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item));

   enit_back #(.NODE_CAPACITY(NODE_CAPACITY), .BUCKET_COUNT(BUCKET_COUNT),
               .BUCKET_WAYS(BUCKET_WAYS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_ready(q_ready),
      .q_item(q_item), .o_valid(rsp_valid), .o_ready(rsp_ready),
      .o_node_id(rsp_node_id), .o_reused(rsp_reused), .o_node_hash(rsp_node_hash),
      .o_status(rsp_status));
endmodule
`default_nettype wire

@@ verif/expression_node_interning_table_tb.sv @@
// expression_node_interning_table_tb: self-checking bench for the interning table.
// Holds its own hash-consing predictor and checks every rsp beat in order.
// Depends on enit_pkg and expression_node_interning_table.
`default_nettype none
module expression_node_interning_table_tb;

   localparam int CAPACITY = 1024;
   localparam int WAYS = 4;
   localparam longint CYCLE_LIMIT = 4000000;

   typedef struct {
      logic [9:0]  node_id;
      logic        reused;
      logic [63:0] node_hash;
      logic [1:0]  status;
   } node_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_kind_code = '0;
   logic [7:0] req_op_code = '0;
   logic req_shareable = 1'b0;
   logic [2:0] req_operand_count = '0;
   logic [9:0] req_operand0_id = '0;
   logic [9:0] req_operand1_id = '0;
   logic [9:0] req_operand2_id = '0;
   logic [9:0] req_operand3_id = '0;
   logic [63:0] req_const_bits = '0;
   logic [63:0] req_name_chars = '0;
   logic [3:0] req_name_len = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [9:0] rsp_node_id;
   logic rsp_reused;
   logic [63:0] rsp_node_hash;
   logic [1:0] rsp_status;

   expression_node_interning_table DUT (.*);

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow copy of the node store and bucket table
   // ---------------------------------------------------------------------
   int unsigned   ids_issued;
   logic [63:0]   sh_hash [CAPACITY];
   logic [2:0]    sh_kind [CAPACITY];
   logic [7:0]    sh_op [CAPACITY];
   logic [3:0]    sh_nlen [CAPACITY];
   logic [2:0]    sh_cnt [CAPACITY];
   logic [9:0]    sh_link [CAPACITY][4];
   logic [63:0]   sh_const [CAPACITY];
   logic [63:0]   sh_name [CAPACITY];
   logic          bkt_valid [256*WAYS];
   logic [9:0]    bkt_id [256*WAYS];

   node_result_type pending_results[$];
   enit_pkg::item_type sent_history[$];   // accepted requests, replayed to provoke reuse
   bit            failed = 1'b0;

   // traffic shaping: percent of cycles the sender idles / receiver stalls
   int unsigned   send_idle_pct = 0;
   int unsigned   recv_stall_pct = 0;
   int unsigned   hold_off_cycles = 0;
   longint        cycle_count = 0;

   function automatic logic [63:0] fnv_fold(logic [63:0] h, logic [63:0] v);
      for (int i = 0; i < 8; i++) begin
         h = h ^ ((v >> (8 * i)) & 64'hff);
         h = h * enit_pkg::FNV_PRIME;
      end
      return h;
   endfunction

   function automatic bit is_nan(logic [63:0] b);
      return b[62:52] == 11'h7ff && b[51:0] != 0;
   endfunction

   // IEEE equality: NaN never matches, signed zeros match
   function automatic bit doubles_match(logic [63:0] a, logic [63:0] b);
      if (is_nan(a) || is_nan(b)) return 1'b0;
      if ((a << 1) == 0 && (b << 1) == 0) return 1'b1;
      return a == b;
   endfunction

   function automatic bit same_node(int unsigned x, int unsigned y);
      if (sh_hash[x] != sh_hash[y] || sh_kind[x] != sh_kind[y] || sh_op[x] != sh_op[y])
         return 1'b0;
      if (sh_cnt[x] != sh_cnt[y]) return 1'b0;
      for (int i = 0; i < sh_cnt[y]; i++)
         if (sh_link[x][i] != sh_link[y][i]) return 1'b0;
      if (sh_kind[y] == enit_pkg::KIND_CONST && !doubles_match(sh_const[x], sh_const[y]))
         return 1'b0;
      if (sh_kind[y] == enit_pkg::KIND_VAR || sh_kind[y] == enit_pkg::KIND_MEMBER ||
          sh_kind[y] == enit_pkg::KIND_ARROW)
         if (sh_nlen[x] != sh_nlen[y] || sh_name[x] != sh_name[y]) return 1'b0;
      return 1'b1;
   endfunction

   // Works out the response for one accepted beat and updates the shadow state.
   function automatic node_result_type intern_node(enit_pkg::item_type it);
      node_result_type r;
      logic [2:0]   cnt;
      logic [3:0]   nlen;
      logic [63:0]  name;
      logic [63:0]  h;
      int unsigned  me, base, free_way;
      r = '{node_id: '0, reused: 1'b0, node_hash: '0, status: enit_pkg::ST_OK};
      cnt = it.cnt > 4 ? 3'd4 : it.cnt;
      nlen = it.nlen > 8 ? 4'd8 : it.nlen;
      name = it.name;
      if (nlen < 8) name &= (64'd1 << (nlen * 8)) - 1;
      if (ids_issued >= CAPACITY) begin
         r.status = enit_pkg::ST_FULL;
         return r;
      end
      for (int i = 0; i < cnt; i++)
         if (it.ids[i] >= ids_issued) begin
            r.status = enit_pkg::ST_BADOP;
            return r;
         end
      h = enit_pkg::FNV_BASIS;
      h = fnv_fold(h, 64'(it.kind));
      h = fnv_fold(h, 64'(it.op));
      h = fnv_fold(h, 64'(cnt));
      for (int i = 0; i < cnt; i++) h = fnv_fold(h, sh_hash[it.ids[i]]);
      for (int i = 0; i < nlen; i++) h = fnv_fold(h, (name >> (8 * i)) & 64'hff);
      if (it.kind == enit_pkg::KIND_CONST) h = fnv_fold(h, it.cbits);
      me = ids_issued;
      ids_issued++;
      sh_hash[me] = h;
      sh_kind[me] = it.kind;
      sh_op[me] = it.op;
      sh_nlen[me] = nlen;
      sh_cnt[me] = cnt;
      for (int i = 0; i < 4; i++) sh_link[me][i] = i < cnt ? it.ids[i] : 10'd0;
      sh_const[me] = it.cbits;
      sh_name[me] = name;
      r.node_id = 10'(me);
      r.node_hash = h;
      if (it.share) begin
         base = h[7:0] * WAYS;
         free_way = WAYS;
         for (int i = 0; i < WAYS; i++) begin
            if (!bkt_valid[base + i]) begin
               free_way = i;
               break;
            end
            if (same_node(bkt_id[base + i], me)) begin
               r.node_id = bkt_id[base + i];
               r.reused = 1'b1;
               break;
            end
         end
         // a full bucket leaves the fresh node unrecorded
         if (!r.reused && free_way < WAYS) begin
            bkt_valid[base + free_way] = 1'b1;
            bkt_id[base + free_way] = 10'(me);
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: one request beat; valid stays up until accepted
   // ---------------------------------------------------------------------
   task automatic send_node(enit_pkg::item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_kind_code <= it.kind;
      req_op_code <= it.op;
      req_shareable <= it.share;
      req_operand_count <= it.cnt;
      req_operand0_id <= it.ids[0];
      req_operand1_id <= it.ids[1];
      req_operand2_id <= it.ids[2];
      req_operand3_id <= it.ids[3];
      req_const_bits <= it.cbits;
      req_name_chars <= it.name;
      req_name_len <= it.nlen;
      do @(posedge clock); while (!req_ready);
      pending_results = {pending_results, intern_node(it)};
      sent_history = {sent_history, it};
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stalls plus an optional long hold-off, counted here.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   function automatic void flag_field(string field, logic [63:0] want, logic [63:0] got);
      $display("%0t mismatch %s: expected %h actual %h", $time, field, want, got);
      failed = 1'b1;
   endfunction

   // Checker: compare each rsp beat against the oldest prediction.
   always @(posedge clock) begin
      node_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected rsp beat: id %h hash %h status %h",
                     $time, rsp_node_id, rsp_node_hash, rsp_status);
            failed = 1'b1;
         end else begin
            want = pending_results.pop_front();
            if (rsp_node_id !== want.node_id)
               flag_field("node_id", 64'(want.node_id), 64'(rsp_node_id));
            if (rsp_reused !== want.reused)
               flag_field("reused", 64'(want.reused), 64'(rsp_reused));
            if (rsp_node_hash !== want.node_hash)
               flag_field("node_hash", want.node_hash, rsp_node_hash);
            if (rsp_status !== want.status)
               flag_field("status", 64'(want.status), 64'(rsp_status));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", pending_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   function automatic enit_pkg::item_type plain_node(logic [2:0] kind, logic [7:0] op,
                                                     logic share);
      enit_pkg::item_type it;
      it = '0;
      it.kind = kind;
      it.op = op;
      it.share = share;
      return it;
   endfunction

   function automatic logic [9:0] live_id();
      if (ids_issued == 0 || $urandom_range(99) < 4) return 10'($urandom_range(1023));
      return 10'($urandom_range(ids_issued > CAPACITY ? CAPACITY - 1 : ids_issued - 1));
   endfunction

   function automatic enit_pkg::item_type random_node();
      enit_pkg::item_type it;
      int unsigned pick;
      // replay an earlier request 35 percent of the time so equal nodes come back for reuse
      if (sent_history.size() > 0 && $urandom_range(99) < 35) begin
         it = sent_history[$urandom_range(sent_history.size() - 1)];
         if ($urandom_range(3) == 0) it.name ^= 64'hff << (8 * $urandom_range(7));
         if ($urandom_range(4) == 0) it.cbits[63] = ~it.cbits[63];
         return it;
      end
      it.kind = 3'($urandom_range(7));
      it.op = $urandom_range(3) == 0 ? 8'd0 : 8'($urandom_range(255));
      it.share = $urandom_range(99) < 80;
      it.cnt = $urandom_range(9) == 0 ? 3'($urandom_range(7)) : 3'($urandom_range(4));
      for (int i = 0; i < 4; i++) it.ids[i] = live_id();
      pick = $urandom_range(9);
      it.cbits = pick == 0 ? 64'h0 : pick == 1 ? 64'h8000000000000000 :
                 pick == 2 ? 64'h7ff8000000000001 : pick == 3 ? 64'h7ff0000000000000 :
                 {$urandom, $urandom};
      it.name = {$urandom, $urandom};
      it.nlen = $urandom_range(9) == 0 ? 4'($urandom_range(15)) : 4'($urandom_range(3));
      return it;
   endfunction

   task automatic test_directed();
      enit_pkg::item_type it;
      it = plain_node(enit_pkg::KIND_BINARY, 8'h2b, 1'b1);   // operand before anything exists
      it.cnt = 3'd1;
      send_node(it);
      it = plain_node(enit_pkg::KIND_CONST, 8'h00, 1'b1);
      send_node(it);                      // +0
      send_node(it);                      // +0 again, reused
      it.cbits = 64'h8000000000000000;
      send_node(it);                      // -0
      it.cbits = 64'h7ff8000000000000;
      send_node(it);
      send_node(it);                      // NaN never matches
      it.cbits = '1;
      send_node(it);
      it.share = 1'b0;
      send_node(it);                      // non-shareable copy
      it = plain_node(enit_pkg::KIND_VAR, 8'hff, 1'b1);
      it.name = 64'hdead_beef_0000_7978;
      it.nlen = 4'd2;
      send_node(it);
      it.name = 64'h1234_5678_9abc_7978;  // bytes above length ignored
      send_node(it);
      it.nlen = 4'd15;                    // length saturates
      it.name = '1;
      send_node(it);
      for (int k = 2; k < 8; k++) begin
         it = plain_node(3'(k), 8'(k * 37), 1'b1);
         it.cnt = 3'd7;                   // count saturates to four
         it.ids = '{10'd3, 10'd2, 10'd1, 10'd0};
         it.name = {8{8'h61 + 8'(k)}};
         it.nlen = 4'd8;
         send_node(it);
         send_node(it);
      end
      it = plain_node(enit_pkg::KIND_UNARY, 8'h2d, 1'b1);
      it.cnt = 3'd1;
      it.ids[0] = 10'h3ff;                // operand not created yet
      send_node(it);
      drain();
   endtask

   // Receiver holds off while the sender keeps offering, so the input backs up.
   task automatic test_backpressure();
      hold_off_cycles = 3000;
      for (int n = 0; n < 12; n++) send_node(random_node());
      drain();
   endtask

   task automatic test_random_traffic();
      int unsigned idle_mix[4][2];
      idle_mix = '{'{0, 0}, '{63, 0}, '{0, 63}, '{35, 35}};
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_mix[ph][0];
         recv_stall_pct = idle_mix[ph][1];
         for (int n = 0; n < 320; n++) send_node(random_node());
         drain();
      end
   endtask

   // Keep going until the store is exhausted, then probe it a few times.
   task automatic test_store_full();
      send_idle_pct = 10;
      recv_stall_pct = 10;
      while (ids_issued < CAPACITY) send_node(random_node());
      for (int n = 0; n < 8; n++) send_node(random_node());
      drain();
   endtask

   initial begin
      for (int i = 0; i < 256 * WAYS; i++) bkt_valid[i] = 1'b0;
      ids_issued = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_traffic();
      test_store_full();
      repeat (400) @(posedge clock);
      if (!failed && pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ filelist.f @@
hdl/enit_pkg.sv
hdl/enit_front.sv
hdl/enit_back.sv
hdl/expression_node_interning_table.sv
verif/expression_node_interning_table_tb.sv
